@@ src/bole_pkg.sv @@
package bole_pkg;

  // Number of cells in the chain
  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 32;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef logic signed [VAL_W-1:0] value_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic       we;
    logic [1:0] func;
    value_t     value;
  } cell_ctrl_t;

endpackage

@@ src/bole_cell.sv @@
module bole_cell (
  input  logic                clk,
  input  bole_pkg::cell_ctrl_t ctrl,
  input  bole_pkg::value_t    left_data,
  input  bole_pkg::value_t    right_data,
  input  logic                occupied,
  input  logic                append_here,
  input  logic                match_in,
  output bole_pkg::value_t    data,
  output logic                match_out
);
  import bole_pkg::*;

  value_t data_r;

  // First-match chain: high from the first equal entry toward the tail
  assign match_out = match_in | (occupied & (data_r == ctrl.value));
  assign data      = data_r;

  // Insert shifts toward the tail, append writes the first free cell, delete closes the gap from the tail side
  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      case (ctrl.func)
        OP_INSERT: data_r <= left_data;
        OP_APPEND: begin
          if (append_here) data_r <= ctrl.value;
        end
        OP_DELETE: begin
          if (match_out) data_r <= right_data;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/bounded_ordered_list_engine_core.sv @@
// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells,
// head in cell 0. Each input item (in_tuser = operation, in_tdata = value)
// runs insert at head, append at tail, delete of the first match, or search,
// and returns one result item. All cells compare and shift in the cycle the
// item is accepted, so one item is taken per clock while the output register
// is free; the result is in the output register on the next cycle. The
// output register alone sets the rate: a new item is taken whenever the
// register is empty or being drained in the same cycle. Insert and append on
// a full list are refused with a full status and leave the list unchanged.
module bounded_ordered_list_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [2] hit, [7:3] count
);
  import bole_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             hit_r, hit_nxt;
  logic [CNT_W-1:0] res_count_r;

  cell_ctrl_t       ctrl;
  value_t           cell_data [DEPTH];
  logic [DEPTH:0]   match_chain;
  logic             accept, full, found;

  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign found     = match_chain[DEPTH];

  // Control broadcast; refused inserts and appends do not write
  always_comb begin
    ctrl.func  = in_tuser;
    ctrl.value = value_t'(in_tdata);
    ctrl.we    = accept & ~(full & ((in_tuser == OP_INSERT) | (in_tuser == OP_APPEND)));
  end

  assign match_chain[0] = 1'b0;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t left_d, right_d;
    if (i == 0) begin : g_head
      assign left_d = ctrl.value;
    end else begin : g_body
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_d = cell_data[i];
    end else begin : g_mid
      assign right_d = cell_data[i+1];
    end
    bole_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .left_data   (left_d),
      .right_data  (right_d),
      .occupied    (CNT_W'(i) < count_r),
      .append_here (CNT_W'(i) == count_r),
      .match_in    (match_chain[i]),
      .data        (cell_data[i]),
      .match_out   (match_chain[i+1])
    );
  end

  // Result and count update
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    hit_nxt    = 1'b0;
    case (in_tuser)
      OP_INSERT, OP_APPEND: begin
        if (full) status_nxt = ST_FULL;
        else      count_nxt  = count_r + CNT_W'(1);
      end
      OP_DELETE: begin
        if (found) begin
          hit_nxt   = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      default: begin
        if (found) hit_nxt    = 1'b1;
        else       status_nxt = ST_MISSING;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept)          out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      hit_r       <= hit_nxt;
      res_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_count_r, hit_r, status_r};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_FULL |-> !hit_r)
    else $error("full status with hit");

  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hit_r |-> status_r == ST_DONE)
    else $error("hit without done status");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> res_count_r == count_r)
    else $error("reported count differs from held count");

  a_search_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser == OP_SEARCH |=> count_r == $past(count_r))
    else $error("search changed count");

endmodule

@@ tb/tb_bounded_ordered_list_engine_core.sv @@
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine_core;
  import bole_pkg::*;

  // Result item as packed on out_tdata: [1:0] status, [2] hit, [7:3] count
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             hit;
    logic [1:0]       status;
  } list_resp_t;

  // One row of the directed table; resp is used only when typed is set
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic [7:0]  reps;
    logic        typed;
    list_resp_t  resp;
  } dir_row_t;

  localparam int N_DIR = 17;
  localparam int N_SEG = 19;
  localparam int SEG_LEN = 100;
  localparam int POOL_N = 6;

  // Empty-list misses, extremes at both ends, fill to full with duplicates,
  // refusals on full, then hits, near miss, first-match delete and deletes
  // at head and in the middle
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{OP_SEARCH, 32'h0000_0000, 8'd1,  1'b1, '{5'd0,  1'b0, ST_MISSING}},
    '{OP_DELETE, 32'hFFFF_FFFF, 8'd1,  1'b1, '{5'd0,  1'b0, ST_MISSING}},
    '{OP_INSERT, 32'h8000_0000, 8'd1,  1'b1, '{5'd1,  1'b0, ST_DONE}},
    '{OP_APPEND, 32'h7FFF_FFFF, 8'd1,  1'b1, '{5'd2,  1'b0, ST_DONE}},
    '{OP_INSERT, 32'h0000_0000, 8'd1,  1'b1, '{5'd3,  1'b0, ST_DONE}},
    '{OP_APPEND, 32'hFFFF_FFFF, 8'd1,  1'b1, '{5'd4,  1'b0, ST_DONE}},
    '{OP_APPEND, 32'h0000_0005, 8'd12, 1'b0, '{5'd0,  1'b0, ST_DONE}},
    '{OP_INSERT, 32'h0000_0001, 8'd1,  1'b1, '{5'd16, 1'b0, ST_FULL}},
    '{OP_APPEND, 32'h0000_0001, 8'd1,  1'b1, '{5'd16, 1'b0, ST_FULL}},
    '{OP_SEARCH, 32'h8000_0000, 8'd1,  1'b0, '{5'd0,  1'b0, ST_DONE}},
    '{OP_SEARCH, 32'h7FFF_FFFF, 8'd1,  1'b0, '{5'd0,  1'b0, ST_DONE}},
    '{OP_SEARCH, 32'h7FFF_FFFE, 8'd1,  1'b0, '{5'd0,  1'b0, ST_DONE}},
    '{OP_DELETE, 32'h0000_0005, 8'd1,  1'b0, '{5'd0,  1'b0, ST_DONE}},
    '{OP_SEARCH, 32'h0000_0005, 8'd1,  1'b0, '{5'd0,  1'b0, ST_DONE}},
    '{OP_DELETE, 32'h0000_0000, 8'd1,  1'b0, '{5'd0,  1'b0, ST_DONE}},
    '{OP_DELETE, 32'h7FFF_FFFF, 8'd1,  1'b0, '{5'd0,  1'b0, ST_DONE}},
    '{OP_DELETE, 32'h0000_0005, 8'd1,  1'b0, '{5'd0,  1'b0, ST_DONE}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic [1:0]  in_tuser;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [1:0] status, [2] hit, [7:3] count

  // Shadow copy of the list, head at index 0
  logic [31:0] shadow_list [DEPTH];
  int          shadow_len;
  int          peak_len;
  logic [31:0] value_pool [POOL_N];
  list_resp_t  pending_resp [$];
  bit          gaps_on;
  int          err_cnt;
  int          n_checked;
  int          n_hits;
  int          n_full;
  int          n_missing;

  bounded_ordered_list_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one operation to the shadow list and return the expected result
  task automatic list_apply(input logic [1:0] f, input logic [31:0] v,
                            output list_resp_t r);
    int pos;
    pos = shadow_len;
    for (int i = shadow_len - 1; i >= 0; i--)
      if (shadow_list[i] == v) pos = i;
    r.status = ST_DONE;
    r.hit    = 1'b0;
    case (f)
      OP_INSERT: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = v;
          shadow_len++;
        end
      end
      OP_APPEND: begin
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = v;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (pos >= shadow_len) begin
          r.status = ST_MISSING;
        end else begin
          for (int i = pos; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          r.hit = 1'b1;
        end
      end
      default: begin
        if (pos >= shadow_len) r.status = ST_MISSING;
        else r.hit = 1'b1;
      end
    endcase
    r.count = CNT_W'(shadow_len);
    if (shadow_len > peak_len) peak_len = shadow_len;
  endtask

  // Operation mix: 0 leans to filling, 1 leans to draining, 2 even
  function automatic logic [1:0] pick_op(input int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      0: return (r < 35) ? OP_INSERT : (r < 70) ? OP_APPEND :
                (r < 85) ? OP_DELETE : OP_SEARCH;
      1: return (r < 15) ? OP_INSERT : (r < 30) ? OP_APPEND :
                (r < 75) ? OP_DELETE : OP_SEARCH;
      default: return 2'(r % 4);
    endcase
  endfunction

  // Mostly values already held or from a small pool so that deletes and
  // searches hit; the rest extremes and full-range noise
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 30 && shadow_len > 0) return shadow_list[$urandom_range(shadow_len - 1)];
    if (r < 70) return value_pool[$urandom_range(POOL_N - 1)];
    if (r < 76) begin
      case ($urandom_range(3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Drive one item from a falling edge, wait for acceptance, record the
  // expectation and return on the next falling edge
  task automatic send_op(input logic [1:0] f, input logic [31:0] v,
                         input bit use_typed, input list_resp_t typed_resp);
    list_resp_t pred;
    while (gaps_on && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    list_apply(f, v, pred);
    pending_resp.push_back(use_typed ? typed_resp : pred);
    @(negedge clk);
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_resp.size() != 0) @(negedge clk);
  endtask

  // Receiver back-pressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= !(gaps_on && $urandom_range(99) < 13);
    end
  end

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk) begin : resp_check
    list_resp_t want;
    list_resp_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_resp.size() == 0) begin
        $display("%0t: result item with none expected: expected none, actual %h",
                 $time, out_tdata);
        err_cnt++;
      end else begin
        want = pending_resp.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, got.status);
          err_cnt++;
        end
        if (got.hit !== want.hit) begin
          $display("%0t: hit mismatch: expected %0d, actual %0d",
                   $time, want.hit, got.hit);
          err_cnt++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count mismatch: expected %0d, actual %0d",
                   $time, want.count, got.count);
          err_cnt++;
        end
        n_checked++;
        if (want.hit) n_hits++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_MISSING) n_missing++;
      end
    end
  end

  // Run time limit
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Main stimulus
  initial begin
    logic [1:0] f;
    logic [31:0] v;
    int wait_cnt;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    gaps_on    = 1'b1;
    shadow_len = 0;
    peak_len   = 0;
    err_cnt    = 0;
    n_checked  = 0;
    n_hits     = 0;
    n_full     = 0;
    n_missing  = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int row = 0; row < N_DIR; row++)
      for (int k = 0; k < DIR_ROWS[row].reps; k++)
        send_op(DIR_ROWS[row].op, DIR_ROWS[row].value, DIR_ROWS[row].typed,
                DIR_ROWS[row].resp);
    wait_drained();

    // Random segments, drained between segments; a few run with no gaps
    for (int seg = 0; seg < N_SEG; seg++) begin
      gaps_on = !(seg >= 8 && seg <= 10);
      for (int p = 0; p < POOL_N; p++) value_pool[p] = $urandom;
      for (int k = 0; k < SEG_LEN; k++) begin
        f = pick_op(seg % 3);
        v = pick_value();
        send_op(f, v, 1'b0, '0);
      end
      wait_drained();
    end

    // Let the output register settle and catch any stray result
    gaps_on = 1'b1;
    wait_cnt = 0;
    while (wait_cnt < 10) begin
      @(posedge clk);
      wait_cnt++;
    end

    $display("Checked %0d result items: %0d hits, %0d misses, %0d refused on full.",
             n_checked, n_hits, n_missing, n_full);
    $display("All four operations driven; list occupancy reached %0d of %0d.",
             peak_len, DEPTH);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ bounded_ordered_list_engine_core.f @@
src/bole_pkg.sv
src/bole_cell.sv
src/bounded_ordered_list_engine_core.sv
tb/tb_bounded_ordered_list_engine_core.sv
